// ===== hdl/mmml_pkg.sv =====
// Package with the shared types, constants and helpers of the min/max/mean logger.
package mmml_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int STORE_BITS  = 48;
  localparam int CH_BITS     = 2;
  localparam int MODE_BITS   = 2;
  localparam int ADDR_BITS   = 2;
  localparam int DATA_BITS   = 32;

  localparam logic [MODE_BITS-1:0] MODE_INST = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_MIN  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_MAX  = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_MEAN = 2'd3;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic [ADDR_BITS-1:0] ADDR_AGG_MODE = 2'd0;

  localparam logic signed [STORE_BITS:0] SAT_HI =
    (STORE_BITS+1)'((64'd1 << (SAMPLE_BITS-1)) - 64'd1);
  localparam logic signed [STORE_BITS:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample_ch0;
    logic signed [SAMPLE_BITS-1:0] sample_ch1;
    logic signed [SAMPLE_BITS-1:0] sample_ch2;
    logic signed [SAMPLE_BITS-1:0] sample_ch3;
    logic [CH_BITS-1:0]            read_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] read_value;
    logic                          invalid;
    logic [COUNT_BITS-1:0]         window_samples;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic div_start;
    logic out_load_div;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic needs_div;
    logic out_free;
    logic div_done;
  } dp_status_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [STORE_BITS:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/multichannel_min_max_mean_logger.sv =====
// Top level of the four-channel windowed min/max/mean logger with its register port.
// A sample beat and a non-mean read need no division; a read result is registered and shows
// in the cycle after acceptance. A mean read of a non-empty window runs the one-bit-per-cycle
// divider; its result is loaded into the output register when the divider is done and the
// output is free, and no beat is taken meanwhile.
// Synchronous active-low reset clears the stores, counters, mode and output valid.
module multichannel_min_max_mean_logger (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mmml_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mmml_pkg::out_item_t                  out_data,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [mmml_pkg::ADDR_BITS-1:0]       cfg_paddr,
  input  logic [mmml_pkg::DATA_BITS-1:0]       cfg_pwdata,
  output logic [mmml_pkg::DATA_BITS-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);

  logic [mmml_pkg::MODE_BITS-1:0] mode_r, mode_nxt;
  mmml_pkg::ctrl_cmd_t  cmd;
  mmml_pkg::dp_status_t status;

  assign cfg_pready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == mmml_pkg::ADDR_AGG_MODE) begin
      mode_nxt = cfg_pwdata[mmml_pkg::MODE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mmml_pkg::MODE_INST;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr == mmml_pkg::ADDR_AGG_MODE) ?
                      mmml_pkg::DATA_BITS'(mode_r) : '0;

  mmml_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mmml_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== hdl/mmml_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module mmml_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [mmml_pkg::STORE_BITS-1:0] dividend,
  input  logic [mmml_pkg::COUNT_BITS-1:0]       divisor,
  output logic                                  done,
  output logic signed [mmml_pkg::STORE_BITS:0]  quotient
);

  localparam int SB = mmml_pkg::STORE_BITS;
  localparam int CB = mmml_pkg::COUNT_BITS;
  localparam int CNT_BITS = $clog2(SB);
  localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(SB - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          neg_r, neg_nxt;
  logic [SB-1:0] q_r, q_nxt;
  logic [CB-1:0] rem_r, rem_nxt;
  logic [CB-1:0] dvs_r, dvs_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CB:0]   rem_sh;
  logic [CB:0]   diff;
  logic          ge;

  assign rem_sh = {rem_r, q_r[SB-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      neg_nxt  = dividend[SB-1];
      q_nxt    = dividend[SB-1] ? SB'(-dividend) : SB'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[SB-2:0], ge};
      rem_nxt = ge ? diff[CB-1:0] : rem_sh[CB-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

// ===== hdl/mmml_datapath.sv =====
// Datapath: channel stores, window counters, divider and output register.
module mmml_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mmml_pkg::MODE_BITS-1:0]  mode,
  input  mmml_pkg::in_item_t              in_data,
  input  logic                            out_stall,
  output logic                            out_valid,
  output mmml_pkg::out_item_t             out_data,
  input  mmml_pkg::ctrl_cmd_t             cmd,
  output mmml_pkg::dp_status_t            status
);

  localparam int NCH = mmml_pkg::CHANNELS;
  localparam int SB  = mmml_pkg::STORE_BITS;
  localparam int CB  = mmml_pkg::COUNT_BITS;
  localparam logic [mmml_pkg::CH_BITS-1:0] CH_LAST = mmml_pkg::CH_BITS'(NCH - 1);

  logic signed [SB-1:0] store_r [NCH];
  logic signed [SB-1:0] store_nxt [NCH];
  logic signed [SB-1:0] s_ext [NCH];
  logic [CB-1:0]        count_r, count_nxt;
  logic [CB-1:0]        latched_r, latched_nxt;
  logic                 out_valid_r, out_valid_nxt;
  mmml_pkg::out_item_t  out_r, out_nxt;
  logic [mmml_pkg::CH_BITS-1:0] ch;
  logic                 ch_ok;
  logic                 is_read;
  logic                 needs_div;
  logic                 direct_load;
  logic                 div_done;
  logic signed [SB:0]   div_q;

  assign ch      = in_data.read_channel;
  assign ch_ok   = 32'(ch) < NCH;
  assign is_read = in_data.func == mmml_pkg::FUNC_READ;
  assign needs_div = is_read && ch_ok && (mode == mmml_pkg::MODE_MEAN) && (count_r != '0);
  assign direct_load = cmd.take && is_read && !needs_div;

  assign s_ext[0] = SB'(in_data.sample_ch0);
  assign s_ext[1] = SB'(in_data.sample_ch1);
  assign s_ext[2] = SB'(in_data.sample_ch2);
  assign s_ext[3] = SB'(in_data.sample_ch3);

  mmml_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (store_r[ch]),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    store_nxt     = store_r;
    count_nxt     = count_r;
    latched_nxt   = latched_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.take) begin
      if (!is_read) begin
        for (int i = 0; i < NCH; i++) begin
          case (mode)
            mmml_pkg::MODE_INST: begin
              store_nxt[i] = s_ext[i];
            end
            mmml_pkg::MODE_MIN: begin
              if (count_r == '0 || s_ext[i] < store_r[i]) store_nxt[i] = s_ext[i];
            end
            mmml_pkg::MODE_MAX: begin
              if (count_r == '0 || s_ext[i] > store_r[i]) store_nxt[i] = s_ext[i];
            end
            default: begin
              store_nxt[i] = store_r[i] + s_ext[i];
            end
          endcase
        end
        if (count_r != '1) count_nxt = count_r + 1'b1;
      end else if (ch_ok) begin
        if (mode != mmml_pkg::MODE_MEAN || count_r != '0) begin
          if (mode == mmml_pkg::MODE_MEAN) store_nxt[ch] = '0;
          if (ch == CH_LAST) begin
            latched_nxt = count_r;
            count_nxt   = '0;
          end
        end
      end
    end
    if (direct_load) begin
      out_valid_nxt          = 1'b1;
      out_nxt.window_samples = latched_nxt;
      out_nxt.invalid        = ch_ok && (mode == mmml_pkg::MODE_MEAN);
      if (ch_ok && mode != mmml_pkg::MODE_MEAN) begin
        out_nxt.read_value = mmml_pkg::sat_sample({store_r[ch][SB-1], store_r[ch]});
      end else begin
        out_nxt.read_value = '0;
      end
    end
    if (cmd.out_load_div) begin
      out_valid_nxt          = 1'b1;
      out_nxt.window_samples = latched_r;
      out_nxt.invalid        = 1'b0;
      out_nxt.read_value     = mmml_pkg::sat_sample(div_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        store_r[i] <= '0;
      end
      count_r     <= '0;
      latched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      store_r     <= store_nxt;
      count_r     <= count_nxt;
      latched_r   <= latched_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign status.is_read   = is_read;
  assign status.needs_div = needs_div;
  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.div_done  = div_done;

endmodule

// ===== hdl/mmml_ctrl.sv =====
// Controller: accepts beats and sequences the mean division and its result load.
module mmml_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mmml_pkg::dp_status_t status,
  output mmml_pkg::ctrl_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE) || (status.is_read && !status.out_free);

  always_comb begin
    state_nxt        = state_r;
    cmd.take         = 1'b0;
    cmd.div_start    = 1'b0;
    cmd.out_load_div = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid && !in_stall;
        if (cmd.take && status.needs_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done && status.out_free) begin
          cmd.out_load_div = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> in_stall)
    else $error("Input accepted during division.");

  a_load_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load_div |-> (status.div_done && status.out_free))
    else $error("Division result loaded too early.");

  a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == ST_DIV) && !status.div_done)
    else $error("Division start did not take effect.");
`endif

endmodule

// ===== dv/mmml_read_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts the logger's read results from observed beats and compares them.
module mmml_read_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  mmml_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  mmml_pkg::out_item_t            out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic                           cfg_pready,
  input  logic [mmml_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [mmml_pkg::DATA_BITS-1:0] cfg_pwdata,
  output int                             fail_count,
  output int                             pending
);

  localparam longint VALUE_MAX = (longint'(1) <<< (mmml_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint VALUE_MIN = -VALUE_MAX - 1;

  logic signed [mmml_pkg::STORE_BITS-1:0] acc [mmml_pkg::CHANNELS];
  logic [mmml_pkg::COUNT_BITS-1:0]        win_cnt;
  logic [mmml_pkg::COUNT_BITS-1:0]        last_cnt;
  logic [mmml_pkg::MODE_BITS-1:0]         agg_mode;
  mmml_pkg::out_item_t                    expected_reads [$];
  int                                     errors = 0;

  task automatic aggregate_beat(input mmml_pkg::in_item_t beat);
    logic signed [mmml_pkg::STORE_BITS-1:0] smp [mmml_pkg::CHANNELS];
    longint                                 sum;
    longint                                 den;
    longint                                 val;
    int                                     ch;
    mmml_pkg::out_item_t                    res;
    smp[0] = mmml_pkg::STORE_BITS'(beat.sample_ch0);
    smp[1] = mmml_pkg::STORE_BITS'(beat.sample_ch1);
    smp[2] = mmml_pkg::STORE_BITS'(beat.sample_ch2);
    smp[3] = mmml_pkg::STORE_BITS'(beat.sample_ch3);
    if (beat.func == mmml_pkg::FUNC_SAMPLE) begin
      for (int i = 0; i < mmml_pkg::CHANNELS; i++) begin
        case (agg_mode)
          mmml_pkg::MODE_INST: begin
            acc[i] = smp[i];
          end
          mmml_pkg::MODE_MIN: begin
            if (win_cnt == '0 || smp[i] < acc[i]) acc[i] = smp[i];
          end
          mmml_pkg::MODE_MAX: begin
            if (win_cnt == '0 || smp[i] > acc[i]) acc[i] = smp[i];
          end
          default: begin
            acc[i] = acc[i] + smp[i];
          end
        endcase
      end
      if (win_cnt != '1) win_cnt = win_cnt + 1'b1;
    end else begin
      res = '0;
      val = 0;
      ch = int'(beat.read_channel);
      if (agg_mode == mmml_pkg::MODE_MEAN) begin
        if (win_cnt == '0) begin
          res.invalid = 1'b1;
        end else begin
          sum = longint'(acc[ch]);
          den = longint'(win_cnt);
          val = sum / den;
          acc[ch] = '0;
          if (ch == mmml_pkg::CHANNELS - 1) begin
            last_cnt = win_cnt;
            win_cnt = '0;
          end
        end
      end else begin
        val = longint'(acc[ch]);
        if (ch == mmml_pkg::CHANNELS - 1) begin
          last_cnt = win_cnt;
          win_cnt = '0;
        end
      end
      if (val > VALUE_MAX) val = VALUE_MAX;
      if (val < VALUE_MIN) val = VALUE_MIN;
      res.read_value = val[mmml_pkg::SAMPLE_BITS-1:0];
      res.window_samples = last_cnt;
      expected_reads.push_back(res);
    end
  endtask

  task automatic check_read(input mmml_pkg::out_item_t got);
    mmml_pkg::out_item_t want;
    if (expected_reads.size() == 0) begin
      $error("read result with none outstanding: read_value %0d", got.read_value);
      errors++;
    end else begin
      want = expected_reads.pop_front();
      if (got.read_value !== want.read_value) begin
        $error("read_value expected %0d got %0d", want.read_value, got.read_value);
        errors++;
      end
      if (got.invalid !== want.invalid) begin
        $error("invalid expected %0d got %0d", want.invalid, got.invalid);
        errors++;
      end
      if (got.window_samples !== want.window_samples) begin
        $error("window_samples expected %0d got %0d", want.window_samples,
               got.window_samples);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mmml_pkg::CHANNELS; i++) acc[i] = '0;
      win_cnt = '0;
      last_cnt = '0;
      agg_mode = mmml_pkg::MODE_INST;
      expected_reads.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == mmml_pkg::ADDR_AGG_MODE) begin
        agg_mode = cfg_pwdata[mmml_pkg::MODE_BITS-1:0];
      end
      if (in_valid && !in_stall) aggregate_beat(in_data);
      if (out_valid && !out_stall) check_read(out_data);
    end
    pending <= expected_reads.size();
    fail_count <= errors;
  end

endmodule

// ===== dv/multichannel_min_max_mean_logger_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the logger: clock, reset, beat and register stimulus, and the verdict.
module multichannel_min_max_mean_logger_tb;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  mmml_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_stall;
  mmml_pkg::out_item_t            out_data;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [mmml_pkg::ADDR_BITS-1:0] cfg_paddr;
  logic [mmml_pkg::DATA_BITS-1:0] cfg_pwdata;
  logic [mmml_pkg::DATA_BITS-1:0] cfg_prdata;
  logic                           cfg_pready;
  int                             fail_count;
  int                             pending;

  int burst_left = 0;
  int sent = 0;
  int stall_left = 0;
  int stall_kind = 0;

  multichannel_min_max_mean_logger dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  mmml_read_checker read_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("[multichannel_min_max_mean_logger] ERROR");
    $finish;
  end

  // The receiver switches between free flow, light, even and heavy stalling.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic logic signed [mmml_pkg::SAMPLE_BITS-1:0] pick_sample();
    logic signed [mmml_pkg::SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 7))
      0: s = 16'sh7fff;
      1: s = 16'sh8000;
      2: s = mmml_pkg::SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
      default: s = mmml_pkg::SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  function automatic mmml_pkg::in_item_t junk_item();
    mmml_pkg::in_item_t b;
    b.func = 1'($urandom_range(0, 1));
    b.sample_ch0 = pick_sample();
    b.sample_ch1 = pick_sample();
    b.sample_ch2 = pick_sample();
    b.sample_ch3 = pick_sample();
    b.read_channel = mmml_pkg::CH_BITS'($urandom_range(0, mmml_pkg::CHANNELS - 1));
    return b;
  endfunction

  task automatic push_item(input mmml_pkg::in_item_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data <= junk_item();
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic put_samples(input logic signed [mmml_pkg::SAMPLE_BITS-1:0] s0,
                             input logic signed [mmml_pkg::SAMPLE_BITS-1:0] s1,
                             input logic signed [mmml_pkg::SAMPLE_BITS-1:0] s2,
                             input logic signed [mmml_pkg::SAMPLE_BITS-1:0] s3);
    mmml_pkg::in_item_t b;
    b = junk_item();
    b.func = mmml_pkg::FUNC_SAMPLE;
    b.sample_ch0 = s0;
    b.sample_ch1 = s1;
    b.sample_ch2 = s2;
    b.sample_ch3 = s3;
    push_item(b);
  endtask

  task automatic put_read(input logic [mmml_pkg::CH_BITS-1:0] ch);
    mmml_pkg::in_item_t b;
    b = junk_item();
    b.func = mmml_pkg::FUNC_READ;
    b.read_channel = ch;
    push_item(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_mode(input logic [mmml_pkg::MODE_BITS-1:0] mode);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= mmml_pkg::ADDR_AGG_MODE;
    cfg_pwdata <= mmml_pkg::DATA_BITS'(mode);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  initial begin
    int target;
    int phase_end;
    int n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset mode copies samples; reads before any sample return zero.
    put_read(2'd0);
    put_samples(16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1);
    put_read(2'd0);
    put_read(2'd1);
    put_read(2'd2);
    put_read(2'd3);

    set_mode(mmml_pkg::MODE_MIN);
    put_samples(16'sd5, -16'sd5, 16'sd100, 16'sh8000);
    put_samples(-16'sd7, 16'sd9, 16'sh7fff, 16'sh0000);
    put_read(2'd0);
    put_read(2'd3);

    set_mode(mmml_pkg::MODE_MAX);
    put_samples(16'sh8000, 16'sh8000, -16'sd1, 16'sd1);
    put_samples(-16'sd32767, 16'sh7fff, -16'sd2, 16'sh0000);
    put_read(2'd1);
    put_read(2'd3);

    // An empty mean window flags invalid and leaves the window open.
    set_mode(mmml_pkg::MODE_MEAN);
    put_read(2'd2);
    put_samples(16'sh8000, 16'sh8000, 16'sd1, -16'sd3);
    put_samples(16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
    put_read(2'd0);
    put_read(2'd1);
    put_read(2'd3);
    repeat (3) put_samples(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);

    // Running sums read in another mode saturate to the sample range.
    set_mode(mmml_pkg::MODE_INST);
    put_read(2'd0);
    set_mode(mmml_pkg::MODE_MIN);
    put_read(2'd1);
    put_read(2'd3);

    target = sent + 1500;
    while (sent < target) begin
      set_mode(mmml_pkg::MODE_BITS'($urandom_range(0, 3)));
      phase_end = sent + $urandom_range(30, 150);
      while (sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          push_item(junk_item());
        end else begin
          n = $urandom_range(0, 10);
          repeat (n) put_samples(pick_sample(), pick_sample(), pick_sample(), pick_sample());
          for (int c = 0; c < mmml_pkg::CHANNELS - 1; c++) begin
            if ($urandom_range(0, 1) == 1) put_read(mmml_pkg::CH_BITS'(c));
          end
          if ($urandom_range(0, 7) != 0) put_read(mmml_pkg::CH_BITS'(mmml_pkg::CHANNELS - 1));
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("[multichannel_min_max_mean_logger] OK");
    end else begin
      $display("[multichannel_min_max_mean_logger] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mmml_pkg.sv
hdl/mmml_div.sv
hdl/mmml_datapath.sv
hdl/mmml_ctrl.sv
hdl/multichannel_min_max_mean_logger.sv
dv/mmml_read_checker.sv
dv/multichannel_min_max_mean_logger_tb.sv
